[hdl/vga_pkg.sv]
package vga_pkg;

	localparam int TableEntriesDefault = 4096;
	localparam int CoordBitsDefault    = 24;
	localparam int CountBitsDefault    = 20;
	localparam int SlotBits            = 12;
	localparam int LeafBits            = 16;
	localparam int BandBits            = 24;
	localparam logic [31:0] HashGolden = 32'h9e3779b9;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_NEW     = 3'd0,
		ST_MERGED  = 3'd1,
		ST_DROPPED = 3'd2,
		ST_INVALID = 3'd3,
		ST_READ    = 3'd4,
		ST_CLEARED = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CFG_LEAF   = 2'd0,
		CFG_BAND_LO = 2'd1,
		CFG_BAND_HI = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLRSWEEP,
		S_KDIV,
		S_HASH,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_WRITE,
		S_RPT_RD,
		S_RPT_LAT,
		S_CDIV,
		S_OUT
	} state_t;

	// 32-bit hash-combine step
	function automatic logic [31:0] hash_mix(input logic [31:0] s, input logic [31:0] k);
		hash_mix = s ^ (k + HashGolden + (s << 6) + (s >> 2));
	endfunction

endpackage

[hdl/voxel_grid_accumulator.sv]
// Voxel-grid accumulator. Each transfer carries one op: add a point, read a slot or clear the
// table; every op but the unused code 3 yields exactly one result transfer, in order. Voxel
// state lives in one synchronous memory word per slot (valid, key, sums, count); TABLE_ENTRIES
// must be a power of two. After reset and on every clear op the block sweeps the whole memory,
// one slot per cycle, with s_axis_tready low. An add runs the floor division (three axes in
// parallel), the hash, a read and a check per probe, one write, two report reads and the
// centroid division, then the output state; a full table drops the point after probing every
// slot. A read of a live slot runs the report reads, the centroid division and the output
// state, a read of an empty slot skips the division, an invalid point goes straight to the
// output state and a clear sweeps the table first. The block takes the next op once the
// result register has loaded. The result register decouples the output: the block takes
// the next op while a result waits, and only the output state of the following op stalls
// until the waiting result leaves. The bit-serial dividers set the pace.
module voxel_grid_accumulator #(
	parameter int TABLE_ENTRIES = vga_pkg::TableEntriesDefault,
	parameter int COORD_BITS    = vga_pkg::CoordBitsDefault,
	parameter int COUNT_BITS    = vga_pkg::CountBitsDefault,
	localparam int IN_W  = ((2 + 3 * COORD_BITS + 1 + vga_pkg::SlotBits + 7) / 8) * 8,
	localparam int OUT_W = ((3 + vga_pkg::SlotBits + 2 + 6 * COORD_BITS + COUNT_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [23:0]      cfg_data,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// op, point_x, point_y, point_z, point_valid, slot (lowest bit up)
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// status, slot_index, occupied, in_band, key_x, key_y, key_z, centroid_x, centroid_y,
	// centroid_z, point_count (lowest bit up)
	output logic [OUT_W-1:0] m_axis_tdata
);
	import vga_pkg::*;

	localparam int AW   = $clog2(TABLE_ENTRIES);
	localparam int CB   = COORD_BITS;
	localparam int NB   = COUNT_BITS;
	localparam int SB   = CB + NB;
	localparam int EW   = 1 + 3 * CB + 3 * SB + NB;
	localparam int PW   = AW + 1;

	// Configuration registers
	logic [LeafBits-1:0] leaf_q;
	logic signed [BandBits-1:0] band_lo_q, band_hi_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_q    <= LeafBits'(150);
			band_lo_q <= BandBits'(200);
			band_hi_q <= BandBits'(2200);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LEAF:    leaf_q    <= cfg_data[LeafBits-1:0];
				CFG_BAND_LO: band_lo_q <= cfg_data[BandBits-1:0];
				CFG_BAND_HI: band_hi_q <= cfg_data[BandBits-1:0];
				default: ;
			endcase
		end
	end

	// Input fields
	logic [1:0] in_op;
	logic signed [CB-1:0] in_x, in_y, in_z;
	logic in_pv;
	logic [SlotBits-1:0] in_slot;
	assign in_op   = s_axis_tdata[1:0];
	assign in_x    = s_axis_tdata[2 +: CB];
	assign in_y    = s_axis_tdata[2 + CB +: CB];
	assign in_z    = s_axis_tdata[2 + 2 * CB +: CB];
	assign in_pv   = s_axis_tdata[2 + 3 * CB];
	assign in_slot = s_axis_tdata[3 + 3 * CB +: SlotBits];

	// Entry memory: valid, key, sums and count per slot
	logic [EW-1:0] mem [TABLE_ENTRIES];
	logic [AW-1:0] mem_addr;
	logic mem_we;
	logic [EW-1:0] mem_wdata, mem_rdata_q;
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		mem_rdata_q <= mem[mem_addr];
	end

	// Control state
	state_t state_q, state_d;
	status_t status_q;
	logic [AW-1:0] slot_q, home_q;
	logic [AW-1:0] sweep_q;
	logic clr_rpt_q;
	logic [PW-1:0] probes_q;
	logic signed [CB-1:0] px_q, py_q, pz_q;
	logic signed [CB-1:0] kx_q, ky_q, kz_q;
	logic [LeafBits-1:0] dleaf_q;
	logic [5:0] step_q;
	logic out_valid_q;
	logic [OUT_W-1:0] out_q, out_d;
	logic out_ld;
	logic occ_q;
	logic oor_q;
	logic [SlotBits-1:0] slot_rd_q;

	// Floor-division serial unit state: unsigned magnitude restoring division
	logic [CB-1:0] fq_x_q, fq_y_q, fq_z_q;
	logic [LeafBits:0] fr_x_q, fr_y_q, fr_z_q;

	// Centroid division unit
	logic [SB-1:0] cq_x_q, cq_y_q, cq_z_q;
	logic [NB:0] cr_x_q, cr_y_q, cr_z_q;
	logic [NB-1:0] cnt_q;
	logic signed [SB-1:0] sx_q, sy_q, sz_q;
	logic signed [CB-1:0] kex_q, key_q, kez_q;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;
	// result register loads when empty or emptied at this edge
	assign out_ld = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

	function automatic logic [CB-1:0] mag(input logic signed [CB-1:0] v);
		mag = v[CB-1] ? CB'(-v) : CB'(v);
	endfunction

	// Serial restoring step
	function automatic logic [LeafBits+CB:0] fstep(input logic [LeafBits:0] r,
		input logic [CB-1:0] q, input logic [LeafBits-1:0] d);
		logic [LeafBits+1:0] t;
		t = {r, q[CB-1]} ;
		if (t >= {1'b0, 1'b0, d})
			fstep = {1'b0, LeafBits'(t - {2'b0, d}), q[CB-2:0], 1'b1};
		else
			fstep = {t[LeafBits:0], q[CB-2:0], 1'b0};
	endfunction

	function automatic logic [NB+SB:0] cstep(input logic [NB:0] r,
		input logic [SB-1:0] q, input logic [NB-1:0] d);
		logic [NB+1:0] t;
		t = {r, q[SB-1]};
		if (t >= {2'b0, d})
			cstep = {1'b0, NB'(t - {2'b0, d}), q[SB-2:0], 1'b1};
		else
			cstep = {t[NB:0], q[SB-2:0], 1'b0};
	endfunction

	// Signed floor from magnitude quotient and remainder
	function automatic logic signed [CB-1:0] fl(input logic neg, input logic [CB-1:0] q,
		input logic [LeafBits:0] r);
		if (!neg) fl = q;
		else if (r != '0) fl = -$signed(q) - CB'(1);
		else fl = -$signed(q);
	endfunction

	function automatic logic [SB-1:0] smag(input logic signed [SB-1:0] v);
		smag = v[SB-1] ? SB'(-v) : SB'(v);
	endfunction

	logic [LeafBits+CB:0] fsx, fsy, fsz;
	logic [NB+SB:0] csx, csy, csz;
	logic [31:0] h0, h1, h2;
	logic ex_vld;
	logic signed [CB-1:0] ex_kx, ex_ky, ex_kz;
	logic signed [SB-1:0] ex_sx, ex_sy, ex_sz;
	logic [NB-1:0] ex_cnt;
	logic hit;
	logic signed [CB-1:0] cen_x, cen_y, cen_z;
	logic inb;

	assign fsx = fstep(fr_x_q, fq_x_q, dleaf_q);
	assign fsy = fstep(fr_y_q, fq_y_q, dleaf_q);
	assign fsz = fstep(fr_z_q, fq_z_q, dleaf_q);
	assign csx = cstep(cr_x_q, cq_x_q, cnt_q);
	assign csy = cstep(cr_y_q, cq_y_q, cnt_q);
	assign csz = cstep(cr_z_q, cq_z_q, cnt_q);

	assign h0 = 32'($signed(kx_q));
	assign h1 = hash_mix(h0, 32'($signed(ky_q)));
	assign h2 = hash_mix(h1, 32'($signed(kz_q)));

	assign {ex_vld, ex_cnt, ex_sz, ex_sy, ex_sx, ex_kz, ex_ky, ex_kx} = mem_rdata_q;
	assign hit = (ex_kx == kx_q) && (ex_ky == ky_q) && (ex_kz == kz_q);

	assign cen_x = sx_q[SB-1] ? -$signed(CB'(cq_x_q)) : $signed(CB'(cq_x_q));
	assign cen_y = sy_q[SB-1] ? -$signed(CB'(cq_y_q)) : $signed(CB'(cq_y_q));
	assign cen_z = sz_q[SB-1] ? -$signed(CB'(cq_z_q)) : $signed(CB'(cq_z_q));
	assign inb = ($signed(cen_z) >= $signed(band_lo_q)) && ($signed(cen_z) <= $signed(band_hi_q));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid && s_axis_tready) begin
					priority case (op_t'(in_op))
						OP_ADD:   state_d = in_pv ? S_KDIV : S_OUT;
						OP_READ:  state_d = S_RPT_RD;
						OP_CLEAR: state_d = S_CLRSWEEP;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_CLRSWEEP: begin
				if (sweep_q == AW'(TABLE_ENTRIES - 1)) state_d = clr_rpt_q ? S_OUT : S_IDLE;
			end
			S_KDIV:      if (step_q == 6'(CB - 1)) state_d = S_HASH;
			S_HASH:      state_d = S_PROBE_RD;
			S_PROBE_RD:  state_d = S_PROBE_CHK;
			S_PROBE_CHK: begin
				if (!ex_vld) state_d = S_WRITE;
				else if (hit) state_d = S_WRITE;
				else if (probes_q == PW'(TABLE_ENTRIES - 1)) state_d = S_OUT;
				else state_d = S_PROBE_RD;
			end
			S_WRITE:     state_d = S_RPT_RD;
			S_RPT_RD:    state_d = S_RPT_LAT;
			S_RPT_LAT:   state_d = (ex_vld && !oor_q) ? S_CDIV : S_OUT;
			S_CDIV:      if (step_q == 6'(SB - 1)) state_d = S_OUT;
			S_OUT:       if (out_ld) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = slot_q;
		mem_wdata = mem_rdata_q;
		if (state_q == S_CLRSWEEP) begin
			mem_we    = 1'b1;
			mem_addr  = sweep_q;
			mem_wdata = '0;
		end else if (state_q == S_WRITE) begin
			mem_we = (status_q != ST_DROPPED);
			if (status_q == ST_NEW)
				mem_wdata = {1'b1, NB'(1), SB'(pz_q), SB'(py_q), SB'(px_q), kz_q, ky_q, kx_q};
			else
				mem_wdata = {1'b1, ex_cnt + NB'(1), ex_sz + SB'(pz_q), ex_sy + SB'(py_q),
					ex_sx + SB'(px_q), ex_kz, ex_ky, ex_kx};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLRSWEEP;
			sweep_q     <= '0;
			clr_rpt_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLRSWEEP) sweep_q <= sweep_q + AW'(1);
			// only the sweep after reset ends without a result
			if (state_q == S_IDLE) clr_rpt_q <= 1'b1;
			if (out_ld) out_valid_q <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	// Result word
	always_comb begin
		out_d = '0;
		out_d[2:0] = status_q;
		if (status_q == ST_READ)
			out_d[3 +: SlotBits] = slot_rd_q;
		else if (status_q != ST_INVALID && status_q != ST_CLEARED)
			out_d[3 +: SlotBits] = SlotBits'(slot_q);
		if (occ_q) begin
			out_d[15] = 1'b1;
			out_d[16] = inb;
			out_d[17 +: CB] = kex_q;
			out_d[17 + CB +: CB] = key_q;
			out_d[17 + 2 * CB +: CB] = kez_q;
			out_d[17 + 3 * CB +: CB] = cen_x;
			out_d[17 + 4 * CB +: CB] = cen_y;
			out_d[17 + 5 * CB +: CB] = cen_z;
			out_d[17 + 6 * CB +: NB] = cnt_q;
		end else if (status_q == ST_DROPPED) begin
			// table full: report the voxel index only
			out_d[17 +: CB] = kx_q;
			out_d[17 + CB +: CB] = ky_q;
			out_d[17 + 2 * CB +: CB] = kz_q;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				px_q <= in_x; py_q <= in_y; pz_q <= in_z;
				dleaf_q <= (leaf_q == '0) ? LeafBits'(1) : leaf_q;
				fq_x_q <= mag(in_x); fq_y_q <= mag(in_y); fq_z_q <= mag(in_z);
				fr_x_q <= '0; fr_y_q <= '0; fr_z_q <= '0;
				step_q <= '0;
				occ_q <= 1'b0;
				slot_q <= AW'(in_slot);
				slot_rd_q <= in_slot;
				oor_q <= (32'(in_slot) >= 32'(TABLE_ENTRIES));
				kx_q <= '0; ky_q <= '0; kz_q <= '0;
				priority case (op_t'(in_op))
					OP_ADD:  status_q <= in_pv ? ST_NEW : ST_INVALID;
					OP_READ: status_q <= ST_READ;
					default: status_q <= ST_CLEARED;
				endcase
				home_q <= AW'(in_slot);
			end
			S_KDIV: begin
				{fr_x_q, fq_x_q} <= fsx;
				{fr_y_q, fq_y_q} <= fsy;
				{fr_z_q, fq_z_q} <= fsz;
				step_q <= step_q + 6'd1;
				if (step_q == 6'(CB - 1)) begin
					kx_q <= fl(px_q[CB-1], fsx[CB-1:0], fsx[LeafBits+CB:CB]);
					ky_q <= fl(py_q[CB-1], fsy[CB-1:0], fsy[LeafBits+CB:CB]);
					kz_q <= fl(pz_q[CB-1], fsz[CB-1:0], fsz[LeafBits+CB:CB]);
				end
			end
			S_HASH: begin
				slot_q <= h2[AW-1:0];
				home_q <= h2[AW-1:0];
				probes_q <= '0;
			end
			S_PROBE_CHK: begin
				if (!ex_vld) status_q <= ST_NEW;
				else if (hit)
					status_q <= (ex_cnt == {NB{1'b1}}) ? ST_DROPPED : ST_MERGED;
				else if (probes_q == PW'(TABLE_ENTRIES - 1)) begin
					status_q <= ST_DROPPED;
					slot_q <= home_q;
				end else begin
					slot_q <= slot_q + AW'(1);
					probes_q <= probes_q + PW'(1);
				end
			end
			S_RPT_LAT: begin
				occ_q <= ex_vld && !oor_q;
				kex_q <= ex_kx; key_q <= ex_ky; kez_q <= ex_kz;
				sx_q <= ex_sx; sy_q <= ex_sy; sz_q <= ex_sz;
				cnt_q <= (ex_cnt == '0) ? NB'(1) : ex_cnt;
				cq_x_q <= smag(ex_sx); cq_y_q <= smag(ex_sy); cq_z_q <= smag(ex_sz);
				cr_x_q <= '0; cr_y_q <= '0; cr_z_q <= '0;
				step_q <= '0;
			end
			S_CDIV: begin
				{cr_x_q, cq_x_q} <= csx;
				{cr_y_q, cq_y_q} <= csy;
				{cr_z_q, cq_z_q} <= csz;
				step_q <= step_q + 6'd1;
			end
			S_OUT: begin
				if (out_ld) out_q <= out_d;
			end
			default: ;
		endcase
	end

endmodule
